[design/sts_pkg.sv]
// shared constants and helpers for the simplex tableau solver
`timescale 1ns / 1ps
package sts_pkg;
  localparam int MAX_VARS = 8;
  localparam int FRAC_BITS = 16;
  localparam int DIM = MAX_VARS + 1;
  localparam int CELLS = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RESULT_LIMIT = 8;
  localparam int NUM_W = 64 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [0:0] ACT_LOAD = 1'b0;
  localparam logic [0:0] ACT_RUN = 1'b1;

  localparam logic [3:0] REG_VAR_COUNT = 4'd0;
  localparam logic [3:0] REG_MAX_PIVOTS = 4'd1;

  localparam logic [1:0] ST_OPTIMAL = 2'd0;
  localparam logic [1:0] ST_NO_ROW = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [NUM_W:0] x);
    logic signed [NUM_W:0] hi;
    logic signed [NUM_W:0] lo;
    begin
      hi = (NUM_W + 1)'(32'sh7fffffff);
      lo = -(NUM_W + 1)'(64'sh80000000);
      if (x > hi) sat32 = 32'sh7fffffff;
      else if (x < lo) sat32 = 32'sh80000000;
      else sat32 = $signed(x[31:0]);
    end
  endfunction
endpackage

[design/simplex_tableau_solver.sv]
// top level of the simplex tableau solver
// usage:
//  s_axis carries requests: tuser is action (0 load, 1 run); tdata holds
//  row, col, value. a load stores one tableau entry and leaves the block idle,
//  so loads can follow back to back.
//  a run repeats pivots until the objective row has no negative entry,
//  a pivot row is missing or max_pivots is reached, then emits one result
//  per constraint row on m_axis (tdata: var_index, solution, status),
//  tlast marking the final one. s_axis is not ready until the last result
//  of a run is taken.
//  cfg carries register writes (index 0 var_count, 1 max_pivots), only idle.
//  one shared serial divider does all ratio and pivot divisions; this divider
//  sets the run time. a run that needs no pivot scans the objective row
//  before its first result, and each further result waits for a new
//  memory read.
//  a 32x32 multiplier is registered before the divider.
//  the memory is read one word per cycle with registered data.
//  reset returns control to idle and sets var_count to 2 and max_pivots to 32; the tableau stays undefined.
//  a stalled m_axis holds the block until each result is taken.
`timescale 1ns / 1ps
module simplex_tableau_solver
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // var_index[2:0], solution[34:3], status[36:35]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0, S_COLRD = 5'd1, S_COLCHK = 5'd2,
    S_CNTCHK = 5'd3, S_RRDA = 5'd4, S_RRDB = 5'd5, S_RDIV = 5'd6,
    S_RNEXT = 5'd7, S_PRD = 5'd8, S_PRDW = 5'd9, S_CRD = 5'd10,
    S_CRDW = 5'd11, S_ERD = 5'd12, S_EOP = 5'd13, S_EDIV = 5'd14,
    S_EWR = 5'd15, S_OUTRD = 5'd16, S_OUTW = 5'd17, S_OUT = 5'd18,
    S_RRDAW = 5'd19, S_EMUL = 5'd20, S_PCRD = 5'd21, S_PCW = 5'd22;

  logic signed [31:0] mem [CELLS];
  logic [ADDR_W-1:0] raddr;
  logic signed [31:0] rdata;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic signed [31:0] wdata;

  logic [4:0] state;
  logic [3:0] var_count;
  logic [7:0] max_pivots;
  logic [7:0] pivot_count;
  logic [3:0] i, j, pc, pr;
  logic [3:0] nxt_row;
  logic signed [31:0] best, p, aic, arj, aij, bestq;
  logic prow_ok;
  logic [1:0] status;
  logic [3:0] k;
  logic [3:0] cnt;
  logic signed [63:0] prod;
  logic load_fire;
  logic signed [31:0] ewr_data;

  // serial divider over magnitudes
  logic div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [NUM_W-1:0] div_num;
  logic [32:0] div_rem;
  logic [31:0] div_den;
  logic div_neg;
  logic [NUM_W:0] div_q;
  logic div_done;
  logic div_start;
  logic signed [NUM_W:0] div_sn;
  logic signed [31:0] div_sd;
  logic [33:0] trial;
  logic q_valid;
  logic signed [31:0] qsat;

  function automatic logic [ADDR_W-1:0] addr(input logic [3:0] r, input logic [3:0] c);
    addr = ADDR_W'(r * DIM + c);
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tlast = (k + 4'd1 == cnt);
  assign m_axis_tdata = {3'd0, status, rdata, k[2:0]};

  assign load_fire = (state == S_IDLE) && s_axis_tvalid && (s_axis_tuser == ACT_LOAD) &&
                     (s_axis_tdata[3:0] <= MAX_VARS) && (s_axis_tdata[7:4] <= MAX_VARS);

  assign nxt_row = (i + 4'd1 == pr) ? i + 4'd2 : i + 4'd1;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    if (i == pr) ewr_data = (j == pc) ? ONE_FX : qsat;
    else if (j == pc) ewr_data = '0;
    else ewr_data = sat32((NUM_W + 1)'(aij) - (NUM_W + 1)'(qsat));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      we <= 1'b0;
    end else if (load_fire) begin
      we <= 1'b1;
      waddr <= addr(s_axis_tdata[3:0], s_axis_tdata[7:4]);
      wdata <= $signed(s_axis_tdata[39:8]);
    end else if (state == S_EWR) begin
      we <= 1'b1;
      waddr <= addr(i, j);
      wdata <= ewr_data;
    end else begin
      we <= 1'b0;
    end
  end

  assign trial = {div_rem, div_num[NUM_W-1]} - {2'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_done <= 1'b0;
      div_cnt <= DIV_CNT_W'(NUM_W);
      div_neg <= div_sn[NUM_W] ^ div_sd[31];
      div_num <= div_sn[NUM_W] ? NUM_W'(-div_sn) : div_sn[NUM_W-1:0];
      div_den <= div_sd[31] ? 32'(-div_sd) : div_sd;
      div_rem <= '0;
      div_q <= '0;
    end else if (div_busy) begin
      div_num <= div_num << 1;
      if (!trial[33]) begin
        div_rem <= trial[32:0];
        div_q <= {div_q[NUM_W-1:0], 1'b1};
      end else begin
        div_rem <= {div_rem[31:0], div_num[NUM_W-1]};
        div_q <= {div_q[NUM_W-1:0], 1'b0};
      end
      div_cnt <= div_cnt - 1'b1;
      div_busy <= (div_cnt != 1);
      div_done <= (div_cnt == 1);
    end else begin
      div_done <= 1'b0;
    end
  end

  logic signed [NUM_W:0] quot;
  assign quot = div_neg ? -$signed(div_q) : $signed(div_q);

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else q_valid <= div_done;
    if (div_done) qsat <= sat32(quot);
  end

  always_ff @(posedge clk) begin
    if (rst) div_start <= 1'b0;
    else div_start <= (state == S_RRDB && aic > 0) || (state == S_EMUL && j != pc);
  end

  always_comb begin
    raddr = '0;
    unique case (state)
      S_COLRD: raddr = addr(var_count, j);
      S_RRDA: raddr = addr(i, pc);
      S_RRDAW: raddr = addr(i, var_count);
      S_PRD: raddr = addr(pr, pc);
      S_CRD: raddr = addr(i, pc);
      S_PCRD: raddr = addr(pr, j);
      S_ERD: raddr = addr(i, j);
      S_OUTRD, S_OUTW, S_OUT: raddr = addr(k, var_count);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      var_count <= 4'd2;
      max_pivots <= 8'd32;
      pivot_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if ({3'd0, cfg_index} == REG_VAR_COUNT) begin
              if (cfg_data[3:0] == 0) var_count <= 4'd1;
              else if (cfg_data[3:0] > MAX_VARS) var_count <= 4'(MAX_VARS);
              else var_count <= cfg_data[3:0];
            end else if ({3'd0, cfg_index} == REG_MAX_PIVOTS) max_pivots <= cfg_data;
          end
          if (s_axis_tvalid && s_axis_tuser == ACT_RUN) begin
            pivot_count <= '0;
            best <= '0; pc <= 4'hf; j <= '0;
            state <= S_COLRD;
          end
        end
        S_COLRD: state <= S_COLCHK;
        S_COLCHK: begin
          if (rdata < best) begin best <= rdata; pc <= j; end
          if (j + 4'd1 == var_count) state <= S_CNTCHK;
          else begin j <= j + 4'd1; state <= S_COLRD; end
        end
        S_CNTCHK: begin
          if (pc == 4'hf) begin status <= ST_OPTIMAL; k <= '0; state <= S_OUTRD; end
          else if (pivot_count >= max_pivots) begin
            status <= ST_LIMIT; k <= '0; state <= S_OUTRD;
          end else begin i <= '0; prow_ok <= 1'b0; state <= S_RRDA; end
        end
        S_RRDA: state <= S_RRDAW;
        S_RRDAW: begin aic <= rdata; state <= S_RRDB; end
        S_RRDB: begin
          if (aic > 0) begin
            div_sn <= (NUM_W + 1)'(rdata) <<< FRAC_BITS;
            div_sd <= aic;
            state <= S_RDIV;
          end else state <= S_RNEXT;
        end
        S_RDIV: if (q_valid) begin
          if (!prow_ok || qsat < bestq) begin
            prow_ok <= 1'b1; pr <= i; bestq <= qsat;
          end
          state <= S_RNEXT;
        end
        S_RNEXT: begin
          if (i + 4'd1 == var_count) begin
            if (!prow_ok) begin status <= ST_NO_ROW; k <= '0; state <= S_OUTRD; end
            else state <= S_PRD;
          end else begin i <= i + 4'd1; state <= S_RRDA; end
        end
        S_PRD: state <= S_PRDW;
        S_PRDW: begin
          p <= rdata;
          i <= (pr == 4'd0) ? 4'd1 : 4'd0;
          state <= S_CRD;
        end
        // non-pivot rows first, pivot row last so old row values stay readable
        S_CRD: state <= S_CRDW;
        S_CRDW: begin aic <= rdata; j <= '0; state <= S_PCRD; end
        S_PCRD: state <= S_PCW;
        S_PCW: begin arj <= rdata; state <= S_ERD; end
        S_ERD: state <= S_EOP;
        S_EOP: begin
          aij <= rdata;
          prod <= aic * arj;
          state <= S_EMUL;
        end
        S_EMUL: begin
          if (j == pc) state <= S_EWR;
          else begin
            if (i == pr) div_sn <= (NUM_W + 1)'(aij) <<< FRAC_BITS;
            else div_sn <= (NUM_W + 1)'(prod);
            div_sd <= p;
            state <= S_EDIV;
          end
        end
        S_EDIV: if (q_valid) state <= S_EWR;
        S_EWR: begin
          if (j != var_count) begin
            j <= j + 4'd1;
            state <= S_PCRD;
          end else if (i == pr) begin
            pivot_count <= pivot_count + 8'd1;
            best <= '0; pc <= 4'hf; j <= '0;
            state <= S_COLRD;
          end else begin
            if (nxt_row > var_count) i <= pr;
            else i <= nxt_row;
            state <= S_CRD;
          end
        end
        S_OUTRD: state <= S_OUTW;
        S_OUTW: state <= S_OUT;
        S_OUT: if (m_axis_tready) begin
          if (k + 4'd1 == cnt) state <= S_IDLE;
          else begin k <= k + 4'd1; state <= S_OUTRD; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cnt = (var_count > RESULT_LIMIT) ? 4'(RESULT_LIMIT) : var_count;
endmodule
